### design/mkdl_pkg.sv
// ----------------------------------------------------------------------------
// mkdl_pkg
// Shared constants and types for the keypad scanner with debounce and latch.
// ----------------------------------------------------------------------------
package mkdl_pkg;

    localparam int ROW_COUNT   = 4;
    localparam int COL_COUNT   = 4;
    localparam int KEY_COUNT   = ROW_COUNT * COL_COUNT;

    localparam int TICK_W      = 32;
    localparam int LEVELS_W    = 16;
    localparam int CODE_W      = 8;
    localparam int KEYMAP_W    = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(5);
    localparam logic [CODE_W-1:0] NO_KEY         = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_TICKS  = 2'd0,
        CFG_KEYMAP_ROWS_0_1 = 2'd1,
        CFG_KEYMAP_ROWS_2_3 = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } t_key_result;

endpackage

### design/mkdl_ifs.sv
// ----------------------------------------------------------------------------
// mkdl_ifs
// Valid/ready channels for scan beats in and key beats out.
// ----------------------------------------------------------------------------
interface mkdl_scan_if;
    logic                          valid;
    logic                          ready;
    logic [mkdl_pkg::TICK_W-1:0]   now_tick;
    logic [mkdl_pkg::LEVELS_W-1:0] matrix_levels;

    modport source (output valid, output now_tick, output matrix_levels, input ready);
    modport sink   (input valid, input now_tick, input matrix_levels, output ready);
endinterface

interface mkdl_key_if;
    logic                        valid;
    logic                        ready;
    logic                        key_valid;
    logic [mkdl_pkg::CODE_W-1:0] key_code;

    modport source (output valid, output key_valid, output key_code, input ready);
    modport sink   (input valid, input key_valid, input key_code, output ready);
endinterface

### design/mkdl_raw_decode.sv
// ----------------------------------------------------------------------------
// mkdl_raw_decode
// Finds the first pressed position in row-major order and maps it through
// the key-code table.
// ----------------------------------------------------------------------------
module mkdl_raw_decode (
    input  logic [mkdl_pkg::LEVELS_W-1:0] i_levels,
    input  logic [mkdl_pkg::KEYMAP_W-1:0] i_keymap_01,
    input  logic [mkdl_pkg::KEYMAP_W-1:0] i_keymap_23,
    output logic [mkdl_pkg::CODE_W-1:0]   o_raw_code
);

    always_comb begin
        logic [mkdl_pkg::KEYMAP_W-1:0] word;
        o_raw_code = mkdl_pkg::NO_KEY;
        for (int r = mkdl_pkg::ROW_COUNT - 1; r >= 0; r--) begin
            word = (r < 2) ? i_keymap_01 : i_keymap_23;
            for (int c = mkdl_pkg::COL_COUNT - 1; c >= 0; c--) begin
                if (!i_levels[r * mkdl_pkg::COL_COUNT + c]) begin
                    o_raw_code = word[(((r % 2) * mkdl_pkg::COL_COUNT + c) % 8)
                                      * mkdl_pkg::CODE_W +: mkdl_pkg::CODE_W];
                end
            end
        end
    end

endmodule

### design/mkdl_debounce.sv
// ----------------------------------------------------------------------------
// mkdl_debounce
// Debounce timer, stable key and press latch. State moves on each advance.
// ----------------------------------------------------------------------------
module mkdl_debounce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [mkdl_pkg::TICK_W-1:0] i_now_tick,
    input  logic [mkdl_pkg::CODE_W-1:0] i_raw_code,
    input  logic [mkdl_pkg::TICK_W-1:0] i_debounce_ticks,
    output mkdl_pkg::t_key_result       o_result
);

    logic [mkdl_pkg::CODE_W-1:0] r_last_raw, n_last_raw;
    logic [mkdl_pkg::TICK_W-1:0] r_change_tick, n_change_tick;
    logic [mkdl_pkg::CODE_W-1:0] r_stable, n_stable;
    logic                        r_latched, n_latched;

    logic [mkdl_pkg::TICK_W-1:0] elapsed;
    logic                        stable_upd;
    logic                        latch_mid;
    logic                        report;

    always_comb begin
        n_last_raw    = i_raw_code;
        n_change_tick = (i_raw_code != r_last_raw) ? i_now_tick : r_change_tick;
        elapsed       = i_now_tick - n_change_tick;
        stable_upd    = (elapsed >= i_debounce_ticks) && (r_stable != n_last_raw);
        n_stable      = stable_upd ? n_last_raw : r_stable;
        latch_mid     = (stable_upd && (n_last_raw == mkdl_pkg::NO_KEY)) ? 1'b0 : r_latched;
        report        = (n_stable != mkdl_pkg::NO_KEY) && !latch_mid;
        n_latched     = latch_mid | report;
        o_result.key_valid = report;
        o_result.key_code  = report ? n_stable : mkdl_pkg::NO_KEY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= mkdl_pkg::NO_KEY;
            r_change_tick <= '0;
            r_stable      <= mkdl_pkg::NO_KEY;
            r_latched     <= 1'b0;
        end else if (i_advance) begin
            r_last_raw    <= n_last_raw;
            r_change_tick <= n_change_tick;
            r_stable      <= n_stable;
            r_latched     <= n_latched;
        end
    end

endmodule

### design/matrix_keypad_debounce_latch.sv
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_latch
// Keypad scanner: row-major key decode, tick-based debounce, press latch.
// ----------------------------------------------------------------------------
// A scan beat passes the input register, then the output register.
// Throughput: one scan beat per cycle unless o_key stalls; the input register,
// decode and debounce logic and output register form a two-stage pipeline.
// Reset (synchronous, active low) empties both stages, sets debounce_ticks
// to 5, clears the key tables and the debounce state.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_latch (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mkdl_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mkdl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mkdl_scan_if.sink                           i_scan,
    mkdl_key_if.source                          o_key
);

    logic [mkdl_pkg::TICK_W-1:0]   r_debounce_ticks;
    logic [mkdl_pkg::KEYMAP_W-1:0] r_keymap_01;
    logic [mkdl_pkg::KEYMAP_W-1:0] r_keymap_23;

    logic                          r_in_valid;
    logic [mkdl_pkg::TICK_W-1:0]   r_in_now;
    logic [mkdl_pkg::LEVELS_W-1:0] r_in_levels;

    logic                          r_out_valid;
    mkdl_pkg::t_key_result         r_out;

    logic                          advance;
    logic [mkdl_pkg::CODE_W-1:0]   raw_code;
    mkdl_pkg::t_key_result         result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= mkdl_pkg::DEBOUNCE_RESET;
            r_keymap_01      <= '0;
            r_keymap_23      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mkdl_pkg::CFG_DEBOUNCE_TICKS:  r_debounce_ticks <= i_cfg_data[mkdl_pkg::TICK_W-1:0];
                mkdl_pkg::CFG_KEYMAP_ROWS_0_1: r_keymap_01      <= i_cfg_data;
                mkdl_pkg::CFG_KEYMAP_ROWS_2_3: r_keymap_23      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign advance      = r_in_valid && (!r_out_valid || o_key.ready);
    assign i_scan.ready = !r_in_valid || !r_out_valid || o_key.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_in_now    <= i_scan.now_tick;
            r_in_levels <= i_scan.matrix_levels;
        end
    end

    mkdl_raw_decode u_decode (
        .i_levels    (r_in_levels),
        .i_keymap_01 (r_keymap_01),
        .i_keymap_23 (r_keymap_23),
        .o_raw_code  (raw_code)
    );

    mkdl_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_now_tick       (r_in_now),
        .i_raw_code       (raw_code),
        .i_debounce_ticks (r_debounce_ticks),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_key.ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_key.valid     = r_out_valid;
    assign o_key.key_valid = r_out.key_valid;
    assign o_key.key_code  = r_out.key_code;

    a_valid_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key.valid && o_key.key_valid) |-> (o_key.key_code != mkdl_pkg::NO_KEY))
        else $error("reported key carries no code");

    a_idle_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key.valid && !o_key.key_valid) |-> (o_key.key_code == mkdl_pkg::NO_KEY))
        else $error("unreported beat carries a key code");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_key.valid && i_scan.ready))
        else $error("pipeline not empty after reset");

endmodule

### sim/tb_matrix_keypad_debounce_latch.sv
// ----------------------------------------------------------------------------
// tb_matrix_keypad_debounce_latch
// Self-checking bench for the keypad scanner with debounce and press latch.
// A short table of directed scans and register writes is followed by random
// phases. Each phase sets the debounce time and the key tables, then sends
// held key patterns with random tick steps. A local model of the decode,
// debounce and latch logic predicts each key beat that the table does not
// give. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_matrix_keypad_debounce_latch;
    timeunit 1ns;
    timeprecision 1ps;

    import mkdl_pkg::*;

    typedef enum logic {
        ROW_SCAN,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [TICK_W-1:0]      tick;
        logic [LEVELS_W-1:0]    levels;
        logic                   typed;
        t_key_result            want;
    } t_dir_row;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;
    localparam logic [KEYMAP_W-1:0]    DIR_KEYMAP_01   = 64'h8807_0605_04FF_0001;
    localparam logic [KEYMAP_W-1:0]    DIR_KEYMAP_23   = 64'hFE17_1615_1413_1200;
    localparam logic [LEVELS_W-1:0]    ALL_RELEASED    = '1;
    localparam int NUM_DIR_ROWS  = 32;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;

    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        '{ROW_SCAN,  '0, '0, 32'd0, 16'h0000, 1'b1, '0},
        '{ROW_WRITE, CFG_INDEX_SPARE, '1, '0, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_KEYMAP_ROWS_0_1, DIR_KEYMAP_01, '0, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_KEYMAP_ROWS_2_3, DIR_KEYMAP_23, '0, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_DEBOUNCE_TICKS, 64'd3, '0, '0, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd10, 16'hFFFF, 1'b1, '0},
        '{ROW_SCAN,  '0, '0, 32'd11, 16'hFFFE, 1'b1, '0},
        '{ROW_SCAN,  '0, '0, 32'd13, 16'hFFFE, 1'b1, '0},
        '{ROW_SCAN,  '0, '0, 32'd14, 16'hFFFE, 1'b1, '{1'b1, 8'h01}},
        '{ROW_SCAN,  '0, '0, 32'd20, 16'hFFFE, 1'b1, '0},
        '{ROW_SCAN,  '0, '0, 32'd21, 16'hFFFF, 1'b1, '0},
        '{ROW_SCAN,  '0, '0, 32'd30, 16'hFFFF, 1'b1, '0},
        '{ROW_SCAN,  '0, '0, 32'd31, 16'hFFF9, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd40, 16'hFFF9, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd41, 16'hFFFB, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd44, 16'hFFFB, 1'b1, '{1'b1, 8'hFF}},
        '{ROW_SCAN,  '0, '0, 32'd45, 16'h7FFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd50, 16'h7FFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd51, 16'hFFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd60, 16'hFFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'hFFFF_FFFE, 16'h7FFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'h0000_0001, 16'h7FFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd2, 16'hFFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd10, 16'hFFFF, 1'b0, '0},
        '{ROW_WRITE, CFG_DEBOUNCE_TICKS, 64'd0, '0, '0, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd11, 16'hEFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd11, 16'hFFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd12, 16'h0000, 1'b0, '0},
        '{ROW_WRITE, CFG_DEBOUNCE_TICKS, 64'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd100, 16'hFFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd99, 16'hFFFF, 1'b0, '0},
        '{ROW_SCAN,  '0, '0, 32'd99, 16'h0000, 1'b0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    mkdl_scan_if scan_if();
    mkdl_key_if  key_if();

    matrix_keypad_debounce_latch DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_scan      (scan_if),
        .o_key       (key_if)
    );

    logic [TICK_W-1:0]   cfg_debounce  = DEBOUNCE_RESET;
    logic [KEYMAP_W-1:0] cfg_keymap_01 = '0;
    logic [KEYMAP_W-1:0] cfg_keymap_23 = '0;

    logic [CODE_W-1:0]   last_raw_code = NO_KEY;
    logic [TICK_W-1:0]   change_tick   = '0;
    logic [CODE_W-1:0]   stable_code   = NO_KEY;
    logic                press_latched = 1'b0;

    t_key_result pending_keys [$];
    int          fail_count = 0;
    bit          scan_calm  = 1'b0;
    bit          key_calm   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_key_result debounce_scan(input logic [TICK_W-1:0] tick,
                                                  input logic [LEVELS_W-1:0] levels);
        logic [CODE_W-1:0]   raw;
        logic [KEYMAP_W-1:0] word;
        logic [TICK_W-1:0]   elapsed;
        t_key_result         res;
        bit                  found;
        int                  row;
        int                  col;
        raw   = NO_KEY;
        found = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (!found && !levels[k]) begin
                found = 1'b1;
                row   = k / COL_COUNT;
                col   = k % COL_COUNT;
                word  = (row < 2) ? cfg_keymap_01 : cfg_keymap_23;
                raw   = word[((row % 2) * COL_COUNT + col) * CODE_W +: CODE_W];
            end
        end
        if (raw != last_raw_code) begin
            last_raw_code = raw;
            change_tick   = tick;
        end
        elapsed = tick - change_tick;
        if (elapsed >= cfg_debounce && stable_code != last_raw_code) begin
            stable_code = last_raw_code;
            if (stable_code == NO_KEY) begin
                press_latched = 1'b0;
            end
        end
        res = '0;
        if (stable_code != NO_KEY && !press_latched) begin
            press_latched = 1'b1;
            res.key_valid = 1'b1;
            res.key_code  = stable_code;
        end
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_keys.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_TICKS:  cfg_debounce  = data[TICK_W-1:0];
            CFG_KEYMAP_ROWS_0_1: cfg_keymap_01 = data;
            CFG_KEYMAP_ROWS_2_3: cfg_keymap_23 = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_scan(input logic [TICK_W-1:0] tick,
                             input logic [LEVELS_W-1:0] levels,
                             input logic typed,
                             input t_key_result want);
        int          gap;
        t_key_result predicted;
        gap = scan_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            scan_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        scan_if.valid         <= 1'b1;
        scan_if.now_tick      <= tick;
        scan_if.matrix_levels <= levels;
        do @(posedge i_clk); while (!scan_if.ready);
        predicted = debounce_scan(tick, levels);
        pending_keys.push_back(typed ? want : predicted);
    endtask

    always @(posedge i_clk) begin : key_check
        t_key_result want;
        if (i_rst_n && key_if.valid && key_if.ready) begin
            if (pending_keys.size() == 0) begin
                $error("key beat with nothing expected: key_valid %0b key_code %0h",
                       key_if.key_valid, key_if.key_code);
                fail_count++;
            end else begin
                want = pending_keys.pop_front();
                if (want.key_valid !== key_if.key_valid) begin
                    $error("key_valid: expected %0b, got %0b", want.key_valid,
                           key_if.key_valid);
                    fail_count++;
                end
                if (want.key_code !== key_if.key_code) begin
                    $error("key_code: expected %0h, got %0h", want.key_code,
                           key_if.key_code);
                    fail_count++;
                end
            end
        end
    end

    initial begin : key_sink
        int stall;
        int beats;
        beats = 0;
        key_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (beats % 32 == 0) begin
                key_calm = ($urandom_range(0, 3) == 0);
            end
            stall = key_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                key_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            key_if.ready <= 1'b1;
            do @(posedge i_clk); while (!key_if.valid);
            beats++;
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        t_dir_row            row;
        logic [TICK_W-1:0]   tick;
        logic [TICK_W-1:0]   step;
        logic [TICK_W-1:0]   debounce;
        logic [KEYMAP_W-1:0] keymap_01;
        logic [KEYMAP_W-1:0] keymap_23;
        logic [LEVELS_W-1:0] pattern;
        int                  sel;
        int                  hold;
        int                  sent;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        scan_if.valid         = 1'b0;
        scan_if.now_tick      = '0;
        scan_if.matrix_levels = ALL_RELEASED;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                scan_if.valid <= 1'b0;
                wait_drained();
                write_cfg(row.reg_idx, row.wdata);
            end else begin
                scan_calm = ($urandom_range(0, 2) == 0);
                send_scan(row.tick, row.levels, row.typed, row.want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       debounce = '0;
                1:       debounce = 32'd1;
                2:       debounce = '1;
                3:       debounce = DEBOUNCE_RESET;
                default: debounce = $urandom_range(2, 12);
            endcase
            for (int b = 0; b < 8; b++) begin
                keymap_01[b*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                keymap_23[b*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            end
            if (p == 2) begin
                keymap_01 = '1;
                keymap_23 = '1;
            end
            scan_if.valid <= 1'b0;
            wait_drained();
            write_cfg(CFG_DEBOUNCE_TICKS, {32'd0, debounce});
            write_cfg(CFG_KEYMAP_ROWS_0_1, keymap_01);
            write_cfg(CFG_KEYMAP_ROWS_2_3, keymap_23);
            write_cfg(CFG_INDEX_SPARE, {$urandom, $urandom});

            tick = $urandom;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sel       = $urandom_range(0, 9);
                hold      = $urandom_range(1, 6);
                scan_calm = ($urandom_range(0, 4) == 0);
                if (sel < 2) begin
                    pattern = ALL_RELEASED;
                end else if (sel < 7) begin
                    pattern = ~(16'h0001 << $urandom_range(0, KEY_COUNT - 1));
                end else if (sel < 9) begin
                    pattern = 16'($urandom);
                    hold    = 1;
                end else begin
                    pattern = 16'($urandom & $urandom);
                end
                repeat (hold) begin
                    sel = $urandom_range(0, 15);
                    if (sel == 0) begin
                        step = $urandom;
                    end else if (sel == 1) begin
                        step = '1;
                    end else begin
                        step = $urandom_range(0, 4);
                    end
                    tick = tick + step;
                    send_scan(tick, pattern, 1'b0, '0);
                    sent++;
                end
            end
        end

        scan_if.valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
